[src/fcf_pkg.sv]
// ----------------------------------------------------------------------------
// FIR convolution filter package
// Shared sizes, request codes, control structs and the saturating add.
// ----------------------------------------------------------------------------
package fcf_pkg;

  localparam int unsigned MAX_TAPS  = 1024;
  localparam int unsigned TAP_IDX_W = $clog2(MAX_TAPS);
  localparam int unsigned NTAPS_W   = TAP_IDX_W + 1;
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned PROD_W    = 2 * DATA_W;
  localparam int unsigned ACC_W     = 48;
  localparam int unsigned OUT_W     = 48;
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned PADDR_W   = 3;

  localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FLUSH  = 2'd2;

  localparam logic [PADDR_W-3:0] REG_NUM_TAPS = '0;
  localparam logic [NTAPS_W-1:0] NUM_TAPS_RST = NTAPS_W'(1);

  typedef struct packed {
    logic shift;
    logic clear;
    logic rotate;
  } cell_ctrl_t;

  typedef struct packed {
    logic clear;
    logic step;
    logic active;
  } mac_ctrl_t;

  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0]  acc,
    input logic signed [PROD_W-1:0] prod
  );
    logic signed [ACC_W:0] sum;
    logic signed [ACC_W-1:0] res;
    sum = {acc[ACC_W-1], acc} + {{(ACC_W+1-PROD_W){prod[PROD_W-1]}}, prod};
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      res = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      res = sum[ACC_W-1:0];
    end
    return res;
  endfunction

endpackage

[src/fcf_if.sv]
// ----------------------------------------------------------------------------
// FIR convolution filter stream interfaces
// Valid/ready channels for filter requests and filter results.
// ----------------------------------------------------------------------------
interface fcf_req_if;
  logic                                valid;
  logic                                ready;
  logic [fcf_pkg::REQ_W-1:0]           req_type;
  logic [fcf_pkg::TAP_IDX_W-1:0]       tap_index;
  logic signed [fcf_pkg::DATA_W-1:0]   data_value;
  logic                                start_of_signal;

  modport source (output valid, req_type, tap_index, data_value, start_of_signal,
                  input ready);
  modport sink   (input valid, req_type, tap_index, data_value, start_of_signal,
                  output ready);
endinterface

interface fcf_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [fcf_pkg::OUT_W-1:0]  output_value;

  modport source (output valid, output_value, input ready);
  modport sink   (input valid, output_value, output ready);
endinterface

[src/fcf_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fcf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/fcf_cell.sv]
// ----------------------------------------------------------------------------
// FIR sample history cell
// Holds one delayed sample; shifts in from one neighbor or rotates from the other.
// ----------------------------------------------------------------------------
module fcf_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fcf_pkg::cell_ctrl_t               ctrl_i,
  input  logic signed [fcf_pkg::DATA_W-1:0] shift_d_i,
  input  logic signed [fcf_pkg::DATA_W-1:0] rot_d_i,
  output logic signed [fcf_pkg::DATA_W-1:0] q_o
);

  logic signed [fcf_pkg::DATA_W-1:0] smp_d, smp_q;

  always_comb begin
    priority if (ctrl_i.shift) begin
      smp_d = ctrl_i.clear ? '0 : shift_d_i;
    end else if (ctrl_i.rotate) begin
      smp_d = rot_d_i;
    end else begin
      smp_d = smp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_q <= '0;
    end else begin
      smp_q <= smp_d;
    end
  end

  assign q_o = smp_q;

endmodule

[src/fcf_mac.sv]
// ----------------------------------------------------------------------------
// FIR multiply-accumulate unit
// Registered product followed by a saturating accumulator.
// ----------------------------------------------------------------------------
module fcf_mac (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fcf_pkg::mac_ctrl_t                ctrl_i,
  input  logic signed [fcf_pkg::DATA_W-1:0] coef_i,
  input  logic signed [fcf_pkg::DATA_W-1:0] sample_i,
  output logic signed [fcf_pkg::ACC_W-1:0]  acc_o
);

  logic signed [fcf_pkg::PROD_W-1:0] mult;
  logic signed [fcf_pkg::PROD_W-1:0] prod_d, prod_q;
  logic                              prod_vld_q;
  logic signed [fcf_pkg::ACC_W-1:0]  acc_q;

  assign mult   = coef_i * sample_i;
  assign prod_d = ctrl_i.active ? mult : '0;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else if (ctrl_i.clear) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      prod_vld_q <= ctrl_i.step;
      if (prod_vld_q) begin
        acc_q <= fcf_pkg::sat_add(acc_q, prod_q);
      end
    end
  end

  assign acc_o = acc_q;

endmodule

[src/fir_convolution_filter_unit.sv]
// ----------------------------------------------------------------------------
// FIR convolution filter unit
// Direct-form FIR over a rotating chain of sample cells and one shared MAC.
// ----------------------------------------------------------------------------
//   Channel   Direction  Carries
//   req_i     in         tap load, audio sample or flush request
//   rsp_o     out        one saturated Q30 sum per sample or flush
//   apb       in/out     num_taps register at address 0
//
// A sample or flush passes through ST_RUN, ST_DRAIN and ST_FIN: the history
// chain rotates once through all 1024 cells, feeding one tap per cycle to the
// multiplier, then ST_DRAIN accumulates the last product and ST_FIN loads the
// output register. The unit then returns to idle and accepts the next request.
// A tap load does not leave idle. Reset clears the history and sets num_taps to 1.
// A result waiting in the output register does not block the next request,
// but the following sum waits until that result has been taken.
module fir_convolution_filter_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  fcf_req_if.sink                             req_i,
  fcf_rsp_if.source                           rsp_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fcf_pkg::PADDR_W-1:0]         paddr,
  input  logic [fcf_pkg::APB_DW-1:0]          pwdata,
  output logic [fcf_pkg::APB_DW-1:0]          prdata,
  output logic                                pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FIN
  } state_e;

  state_e                                state_q;
  logic [fcf_pkg::TAP_IDX_W-1:0]         cnt_q;
  logic                                  out_vld_q;
  logic signed [fcf_pkg::OUT_W-1:0]      out_q;
  logic [fcf_pkg::NTAPS_W-1:0]           num_taps_q;

  logic                                  req_acc;
  logic                                  is_smp;
  logic                                  smp_acc;
  logic                                  load_acc;
  logic signed [fcf_pkg::DATA_W-1:0]     new_smp;
  logic [fcf_pkg::TAP_IDX_W-1:0]         raddr;
  logic signed [fcf_pkg::DATA_W-1:0]     coef;
  logic signed [fcf_pkg::ACC_W-1:0]      acc;
  logic                                  out_free;
  fcf_pkg::cell_ctrl_t                   cell_ctrl;
  fcf_pkg::cell_ctrl_t                   head_ctrl;
  fcf_pkg::mac_ctrl_t                    mac_ctrl;
  logic signed [fcf_pkg::DATA_W-1:0]     hist [fcf_pkg::MAX_TAPS];
  logic                                  cfg_we;
  logic [fcf_pkg::PADDR_W-3:0]           cfg_idx;

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[fcf_pkg::PADDR_W-1:2];
  assign cfg_we  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_taps_q <= fcf_pkg::NUM_TAPS_RST;
    end else if (cfg_we && cfg_idx == fcf_pkg::REG_NUM_TAPS) begin
      num_taps_q <= pwdata[fcf_pkg::NTAPS_W-1:0];
    end
  end

  assign prdata = (cfg_idx == fcf_pkg::REG_NUM_TAPS) ?
                  fcf_pkg::APB_DW'(num_taps_q) : '0;

  // Request decode.
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid & req_i.ready;
  assign is_smp      = (req_i.req_type == fcf_pkg::REQ_SAMPLE) ||
                       (req_i.req_type == fcf_pkg::REQ_FLUSH);
  assign smp_acc     = req_acc & is_smp;
  assign load_acc    = req_acc & (req_i.req_type == fcf_pkg::REQ_LOAD);
  assign new_smp     = (req_i.req_type == fcf_pkg::REQ_FLUSH) ? '0 : req_i.data_value;

  // Coefficient store.
  assign raddr = (state_q == ST_RUN) ? cnt_q + 1'b1 : '0;

  fcf_ram #(
    .WIDTH (fcf_pkg::DATA_W),
    .DEPTH (fcf_pkg::MAX_TAPS)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (load_acc),
    .waddr_i (req_i.tap_index),
    .wdata_i (req_i.data_value),
    .raddr_i (raddr),
    .rdata_o (coef)
  );

  // Sample history chain: cell k holds the sample delayed by k.
  assign cell_ctrl = '{shift:  smp_acc,
                       clear:  req_i.start_of_signal,
                       rotate: (state_q == ST_RUN)};
  assign head_ctrl = '{shift: cell_ctrl.shift, clear: 1'b0, rotate: cell_ctrl.rotate};

  for (genvar k = 0; k < fcf_pkg::MAX_TAPS; k++) begin : g_cell
    if (k == 0) begin : g_head
      fcf_cell u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .ctrl_i    (head_ctrl),
        .shift_d_i (new_smp),
        .rot_d_i   (hist[1]),
        .q_o       (hist[0])
      );
    end else begin : g_body
      fcf_cell u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .ctrl_i    (cell_ctrl),
        .shift_d_i (hist[k-1]),
        .rot_d_i   (hist[(k+1) % fcf_pkg::MAX_TAPS]),
        .q_o       (hist[k])
      );
    end
  end

  // Multiply-accumulate.
  assign mac_ctrl = '{clear:  smp_acc,
                      step:   (state_q == ST_RUN),
                      active: ({1'b0, cnt_q} < num_taps_q)};

  fcf_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .coef_i   (coef),
    .sample_i (hist[0]),
    .acc_o    (acc)
  );

  // Sequencer and output register.
  assign out_free = !out_vld_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
      out_q     <= '0;
    end else begin
      if (state_q == ST_FIN && out_free) begin
        out_q     <= fcf_pkg::OUT_W'(acc);
        out_vld_q <= 1'b1;
      end else if (out_vld_q && rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (smp_acc) begin
            cnt_q   <= '0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == fcf_pkg::TAP_IDX_W'(fcf_pkg::MAX_TAPS - 1)) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.output_value = out_q;

endmodule

[src/fcf_checker.sv]
// ----------------------------------------------------------------------------
// FIR convolution filter port checker
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
module fcf_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              req_valid_i,
  input logic                              req_ready_i,
  input logic [fcf_pkg::REQ_W-1:0]         req_type_i,
  input logic                              rsp_valid_i,
  input logic                              rsp_ready_i,
  input logic signed [fcf_pkg::OUT_W-1:0]  rsp_value_i
);

  logic req_acc;
  assign req_acc = req_valid_i & req_ready_i;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("Result valid dropped before it was taken.");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_value_i))
    else $error("Stalled result changed.");

  a_busy_after_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc && (req_type_i == fcf_pkg::REQ_SAMPLE || req_type_i == fcf_pkg::REQ_FLUSH)
    |=> !req_ready_i)
    else $error("Request taken while a sum was being computed.");

  a_load_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc && req_type_i == fcf_pkg::REQ_LOAD |=> req_ready_i)
    else $error("Tap load did not complete in one cycle.");

  a_rsp_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(!req_ready_i))
    else $error("Result appeared without a computation in progress.");

endmodule

bind fir_convolution_filter_unit fcf_checker u_fcf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .req_type_i  (req_i.req_type),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_value_i (rsp_o.output_value)
);

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// FIR convolution filter unit testbench
// Streams tap loads, audio samples and flush requests through the filter,
// with random gaps on both channels and a long output stall. The tap count
// is changed over APB between phases. Each result is checked against a
// local fixed-point convolution of the same request stream.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fcf_pkg::*;

  localparam logic [REQ_W-1:0]   REQ_UNUSED    = 2'd3;
  localparam logic [PADDR_W-1:0] ADDR_NUM_TAPS = {REG_NUM_TAPS, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_SPARE    = 3'd4;
  localparam int unsigned        CYCLE_LIMIT   = 6_000_000;
  localparam int unsigned        PHASE_BUDGET  = 53;
  localparam int unsigned        NUM_PHASES    = 11;

  typedef struct packed {
    logic [REQ_W-1:0]         kind;
    logic [TAP_IDX_W-1:0]     idx;
    logic signed [DATA_W-1:0] value;
    logic                     sof;
  } req_item_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [APB_DW-1:0]  pwdata;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  fcf_req_if req_if ();
  fcf_rsp_if rsp_if ();

  fir_convolution_filter_unit DUT (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  req_item_t                 pending_reqs[$];
  logic signed [OUT_W-1:0]   expected_sums[$];
  logic signed [DATA_W-1:0]  coef_mem [MAX_TAPS];
  logic signed [DATA_W-1:0]  history [MAX_TAPS];
  logic [TAP_IDX_W-1:0]      hist_ptr;
  logic [NTAPS_W-1:0]        cfg_taps;

  req_item_t   drive_item;
  logic        req_taken;
  int unsigned req_gap_left;
  int unsigned rsp_gap_left;
  int unsigned rsp_hold_left;
  bit          req_idle_mode;
  bit          rsp_idle_mode;
  int unsigned queued_count;
  int unsigned error_count;
  int unsigned cycle_count;

  int unsigned phase_taps [NUM_PHASES] =
    '{1024, 16, 2047, 1, 5, 1500, 0, 700, 2, 1025, 64};

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  function automatic logic signed [OUT_W-1:0] filter_sum();
    longint acc_max;
    longint acc_min;
    longint acc;
    longint prod;
    int unsigned n_active;
    logic [TAP_IDX_W-1:0] pos;
    acc_max = (longint'(1) <<< (ACC_W - 1)) - 1;
    acc_min = -acc_max - 1;
    acc = 0;
    n_active = (cfg_taps > MAX_TAPS) ? MAX_TAPS : cfg_taps;
    pos = hist_ptr;
    for (int unsigned m = 0; m < n_active; m++) begin
      prod = longint'(coef_mem[m]) * longint'(history[pos]);
      if (prod > 0 && acc > acc_max - prod) begin
        acc = acc_max;
      end else if (prod < 0 && acc < acc_min - prod) begin
        acc = acc_min;
      end else begin
        acc = acc + prod;
      end
      pos = pos - 1'b1;
    end
    return OUT_W'(acc);
  endfunction

  task automatic apply_request(input req_item_t r);
    case (r.kind)
      REQ_LOAD: begin
        coef_mem[r.idx] = r.value;
      end
      REQ_SAMPLE, REQ_FLUSH: begin
        if (r.sof) begin
          foreach (history[i]) history[i] = '0;
          hist_ptr = '0;
        end else begin
          hist_ptr = hist_ptr + 1'b1;
        end
        history[hist_ptr] = (r.kind == REQ_FLUSH) ? '0 : r.value;
        expected_sums.push_back(filter_sum());
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    req_item_t       seen;
    logic signed [OUT_W-1:0] want;
    req_taken <= req_if.valid && req_if.ready;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("fir_convolution_filter_unit verification failed");
      $finish;
    end
    if (rst_n) begin
      if (req_if.valid && req_if.ready) begin
        seen.kind  = req_if.req_type;
        seen.idx   = req_if.tap_index;
        seen.value = req_if.data_value;
        seen.sof   = req_if.start_of_signal;
        apply_request(seen);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_sums.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d", rsp_if.output_value));
        end else begin
          want = expected_sums.pop_front();
          if (rsp_if.output_value !== want) begin
            report_mismatch($sformatf("output_value %0d, expected %0d",
                                      rsp_if.output_value, want));
          end
        end
      end
    end
  end

  function automatic int unsigned pick_req_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!req_idle_mode || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 30);
    return $urandom_range(100, 400);
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_taken) begin
      if (req_gap_left > 0) begin
        req_if.valid <= 1'b0;
        req_gap_left = req_gap_left - 1;
      end else if (pending_reqs.size() > 0) begin
        drive_item = pending_reqs.pop_front();
        req_if.req_type        <= drive_item.kind;
        req_if.tap_index       <= drive_item.idx;
        req_if.data_value      <= drive_item.value;
        req_if.start_of_signal <= drive_item.sof;
        req_if.valid           <= 1'b1;
        req_gap_left = pick_req_gap();
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    int unsigned r;
    if (rsp_hold_left > 0) begin
      rsp_if.ready <= 1'b0;
      rsp_hold_left = rsp_hold_left - 1;
    end else if (rsp_gap_left > 0) begin
      rsp_if.ready <= 1'b0;
      rsp_gap_left = rsp_gap_left - 1;
    end else if (rsp_idle_mode && rsp_if.valid && $urandom_range(0, 99) < 40) begin
      r = $urandom_range(0, 99);
      rsp_if.ready <= 1'b0;
      if (r < 70) begin
        rsp_gap_left = $urandom_range(0, 2);
      end else if (r < 95) begin
        rsp_gap_left = $urandom_range(3, 29);
      end else begin
        rsp_gap_left = $urandom_range(100, 1500);
      end
    end else if (rsp_idle_mode && $urandom_range(0, 99) < 10) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  function automatic logic signed [DATA_W-1:0] pick_q15();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return -16'sd32768;
    if (r < 12) return 16'sd32767;
    if (r < 15) return '0;
    if (r < 18) return -16'sd1;
    return DATA_W'($urandom);
  endfunction

  task automatic push_req(input logic [REQ_W-1:0] kind, input logic [TAP_IDX_W-1:0] idx,
                          input logic signed [DATA_W-1:0] value, input logic sof);
    req_item_t r;
    r.kind  = kind;
    r.idx   = idx;
    r.value = value;
    r.sof   = sof;
    pending_reqs.push_back(r);
    if (kind != REQ_UNUSED) queued_count++;
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || req_if.valid || expected_sums.size() != 0) begin
      @(posedge clk);
    end
    repeat (16) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [APB_DW-1:0] data);
    logic [APB_DW-1:0] readback;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_NUM_TAPS) cfg_taps = data[NTAPS_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_NUM_TAPS) begin
      @(negedge clk);
      psel  <= 1'b1;
      paddr <= addr;
      @(negedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      readback = prdata;
      @(negedge clk);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (readback !== APB_DW'(cfg_taps)) begin
        report_mismatch($sformatf("num_taps read %0d, expected %0d", readback, cfg_taps));
      end
    end
  endtask

  task automatic run_random_phase(input int unsigned budget);
    int unsigned start_count;
    int unsigned n_samples;
    int unsigned n_flush;
    start_count = queued_count;
    while (queued_count - start_count < budget) begin
      n_samples = $urandom_range(1, 12);
      if (cfg_taps >= 1 && cfg_taps <= 16) begin
        n_flush = cfg_taps - 1;
      end else begin
        n_flush = $urandom_range(0, 4);
      end
      push_req(REQ_SAMPLE, TAP_IDX_W'($urandom), pick_q15(), $urandom_range(0, 99) < 80);
      for (int unsigned i = 1; i < n_samples + n_flush; i++) begin
        if ($urandom_range(0, 99) < 15) begin
          push_req(REQ_LOAD, TAP_IDX_W'($urandom), pick_q15(), 1'($urandom));
        end
        if ($urandom_range(0, 99) < 4) begin
          push_req(REQ_UNUSED, TAP_IDX_W'($urandom), DATA_W'($urandom), 1'($urandom));
        end
        push_req((i < n_samples) ? REQ_SAMPLE : REQ_FLUSH, TAP_IDX_W'($urandom),
                 (i < n_samples) ? pick_q15() : DATA_W'($urandom),
                 $urandom_range(0, 99) < 3);
      end
    end
  endtask

  initial begin
    rst_n                  = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    req_if.valid           = 1'b0;
    req_if.req_type        = REQ_LOAD;
    req_if.tap_index       = '0;
    req_if.data_value      = '0;
    req_if.start_of_signal = 1'b0;
    rsp_if.ready           = 1'b0;
    req_taken              = 1'b0;
    req_gap_left           = 0;
    rsp_gap_left           = 0;
    rsp_hold_left          = 0;
    req_idle_mode          = 1'b1;
    rsp_idle_mode          = 1'b1;
    queued_count           = 0;
    error_count            = 0;
    cycle_count            = 0;
    hist_ptr               = '0;
    cfg_taps               = NUM_TAPS_RST;
    foreach (history[i]) history[i] = '0;
    foreach (coef_mem[i]) coef_mem[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    push_req(REQ_LOAD, 10'd0, 16'sd32767, 1'b0);
    push_req(REQ_SAMPLE, 10'd0, 16'sd32767, 1'b1);
    push_req(REQ_SAMPLE, 10'd1023, -16'sd32768, 1'b0);
    push_req(REQ_FLUSH, 10'd512, 16'sd12345, 1'b0);
    push_req(REQ_LOAD, 10'd0, -16'sd32768, 1'b1);
    push_req(REQ_SAMPLE, 10'd0, -16'sd32768, 1'b0);
    push_req(REQ_LOAD, 10'd1, -16'sd32768, 1'b0);
    push_req(REQ_LOAD, 10'd2, 16'sd32767, 1'b0);
    push_req(REQ_LOAD, 10'd3, -16'sd1, 1'b0);
    push_req(REQ_LOAD, 10'd4, 16'sd1, 1'b0);
    push_req(REQ_LOAD, 10'd5, 16'sd0, 1'b0);
    push_req(REQ_LOAD, 10'd6, 16'sd12345, 1'b0);
    push_req(REQ_LOAD, 10'd7, -16'sd23456, 1'b0);
    push_req(REQ_LOAD, 10'd1023, -16'sd1, 1'b0);
    wait_idle();
    cfg_write(ADDR_NUM_TAPS, 32'd8);
    push_req(REQ_SAMPLE, 10'd0, -16'sd32768, 1'b1);
    push_req(REQ_SAMPLE, 10'd0, 16'sd32767, 1'b0);
    push_req(REQ_UNUSED, 10'd1023, 16'sd32767, 1'b1);
    for (int i = 0; i < 7; i++) push_req(REQ_FLUSH, 10'd0, -16'sd1, 1'b0);
    wait_idle();
    cfg_write(ADDR_NUM_TAPS, 32'd0);
    push_req(REQ_SAMPLE, 10'd0, 16'sd1, 1'b1);
    wait_idle();
    cfg_write(ADDR_SPARE, 32'h0000_07FF);
    push_req(REQ_SAMPLE, 10'd0, 16'sd32767, 1'b0);
    wait_idle();

    for (int i = 0; i < MAX_TAPS; i++) begin
      push_req(REQ_LOAD, TAP_IDX_W'(i), pick_q15(), 1'($urandom));
    end
    wait_idle();

    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      cfg_write(ADDR_NUM_TAPS, APB_DW'(phase_taps[p]));
      @(posedge clk);
      if (p == 1) begin
        req_idle_mode = 1'b0;
        rsp_idle_mode = 1'b0;
        rsp_hold_left = 6000;
      end else begin
        req_idle_mode = ($urandom_range(0, 3) != 0);
        rsp_idle_mode = ($urandom_range(0, 3) != 0);
      end
      run_random_phase(PHASE_BUDGET);
      wait_idle();
    end

    repeat (1100) @(posedge clk);
    if (expected_sums.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_sums.size()));
    end
    if (error_count == 0) begin
      $display("fir_convolution_filter_unit verification clean");
    end else begin
      $display("fir_convolution_filter_unit verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
src/fcf_pkg.sv
src/fcf_if.sv
src/fcf_ram.sv
src/fcf_cell.sv
src/fcf_mac.sv
src/fir_convolution_filter_unit.sv
src/fcf_checker.sv
tb/sv/testbench.sv
